/* rtl/ppp_pkg.sv */
// Shared types and constants for the polyline path point and parameter core.
// Used by ppp_ctrl, ppp_dp and the top level; depends on nothing.
package ppp_pkg;

    localparam int CRD_W     = 24;
    localparam int PAR_W     = 17;
    localparam int DIF_W     = 25;
    localparam int MUL_W     = 26;
    localparam int PRD_W     = 52;
    localparam int DST_W     = 51;
    localparam int PROJ_BITS = 16;
    localparam int FD_BITS   = 27;
    localparam int CNT_W     = 5;
    localparam logic [PAR_W-1:0] ONE_Q16 = 17'd65536;

    typedef enum logic [1:0] {
        REQ_ADD     = 2'd0,
        REQ_POS     = 2'd1,
        REQ_CLOSEST = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_SHORT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        TC_ZERO,
        TC_ONE,
        TC_DIV
    } t_tcase;

    typedef enum logic [5:0] {
        OP_NONE,
        OP_LOAD,
        OP_ADD,
        OP_SHORT,
        OP_ZERO,
        OP_POS_T,
        OP_POS_RA,
        OP_POS_R0,
        OP_POS_R1,
        OP_POS_W,
        OP_POS_D,
        OP_POS_MX,
        OP_POS_MY,
        OP_POS_FIN,
        OP_CL_R0,
        OP_CL_R1,
        OP_CL_B,
        OP_CL_D,
        OP_CL_M1,
        OP_CL_M2,
        OP_CL_M3,
        OP_CL_M4,
        OP_CL_M5,
        OP_CL_T,
        OP_CL_DIV,
        OP_CL_CX,
        OP_CL_CY,
        OP_CL_EX,
        OP_CL_EY,
        OP_CL_CMP,
        OP_CL_NEXT,
        OP_FD_INIT,
        OP_FD,
        OP_FD_END,
        OP_EMIT
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_POS_RA,
        S_POS_R0,
        S_POS_R1,
        S_POS_W,
        S_POS_D,
        S_POS_MX,
        S_POS_MY,
        S_POS_FIN,
        S_CL_R1,
        S_CL_B,
        S_CL_D,
        S_CL_M1,
        S_CL_M2,
        S_CL_M3,
        S_CL_M4,
        S_CL_M5,
        S_CL_T,
        S_CL_DIV,
        S_CL_CX,
        S_CL_CY,
        S_CL_EX,
        S_CL_EY,
        S_CL_CMP,
        S_CL_NEXT,
        S_FD_INIT,
        S_FD,
        S_FD_END,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        t_req   req;
        logic   full;
        logic   short_path;
        logic   seg_last;
        t_tcase tcase;
        logic   proj_last;
        logic   fd_last;
        logic   out_free;
    } t_stat;

endpackage

/* rtl/polyline_path_point_and_parameter_core.sv */
// Top level of the polyline path point and parameter core.
// Depends on ppp_pkg, ppp_ctrl, ppp_dp (and ppp_ram through ppp_dp).
//
// Usage:
//   Input channel i_valid / o_stall carries one request per transaction:
//   add vertex, position at parameter, or closest point parameter.
//   Output channel o_valid / i_stall returns exactly one result per request.
//   One request is worked at a time; the next is taken as soon as the
//   sequencer is back in idle, even while a result still waits in the
//   output register.
//   Closest point time grows with the number of segments, and with every
//   projection that runs the fraction divider. The request times are set by
//   the shared 26x26 multiplier, the one-port vertex RAM and the bit-serial
//   fraction and final-parameter dividers.
//   Reset empties the path; vertex RAM contents are not cleared.
//   While the receiver stalls, the result holds and a finished request
//   waits in its last state before returning to idle.
module polyline_path_point_and_parameter_core #(
    parameter int MAX_POINTS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_req_type,
    input  logic signed [ppp_pkg::CRD_W-1:0]  i_point_x,
    input  logic signed [ppp_pkg::CRD_W-1:0]  i_point_y,
    input  logic [ppp_pkg::PAR_W-1:0]         i_path_param,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [ppp_pkg::CRD_W-1:0]  o_out_x,
    output logic signed [ppp_pkg::CRD_W-1:0]  o_out_y,
    output logic [ppp_pkg::PAR_W-1:0]         o_out_param,
    output logic [1:0]                        o_status
);

    ppp_pkg::t_cmd  cmd;
    ppp_pkg::t_stat st;

    ppp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    ppp_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_st         (st),
        .i_req_type   (i_req_type),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_path_param (i_path_param),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_param  (o_out_param),
        .o_status     (o_status)
    );

endmodule

/* rtl/ppp_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module ppp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ppp_ctrl.sv */
// Sequencer for the polyline core: walks each request through the datapath.
// Depends on ppp_pkg.
module ppp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  ppp_pkg::t_stat i_st,
    output ppp_pkg::t_cmd  o_cmd
);

    ppp_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd.op  = ppp_pkg::OP_NONE;
        o_stall   = 1'b1;
        unique case (r_state)
            ppp_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.op = ppp_pkg::OP_LOAD;
                    n_state  = ppp_pkg::S_DISP;
                end
            end
            ppp_pkg::S_DISP: begin
                unique case (i_st.req)
                    ppp_pkg::REQ_ADD: begin
                        o_cmd.op = ppp_pkg::OP_ADD;
                        n_state  = ppp_pkg::S_DONE;
                    end
                    ppp_pkg::REQ_POS: begin
                        if (i_st.short_path) begin
                            o_cmd.op = ppp_pkg::OP_SHORT;
                            n_state  = ppp_pkg::S_DONE;
                        end else begin
                            o_cmd.op = ppp_pkg::OP_POS_T;
                            n_state  = ppp_pkg::S_POS_RA;
                        end
                    end
                    ppp_pkg::REQ_CLOSEST: begin
                        if (i_st.short_path) begin
                            o_cmd.op = ppp_pkg::OP_SHORT;
                            n_state  = ppp_pkg::S_DONE;
                        end else begin
                            o_cmd.op = ppp_pkg::OP_CL_R0;
                            n_state  = ppp_pkg::S_CL_R1;
                        end
                    end
                    default: begin
                        o_cmd.op = ppp_pkg::OP_ZERO;
                        n_state  = ppp_pkg::S_DONE;
                    end
                endcase
            end
            ppp_pkg::S_POS_RA: begin
                o_cmd.op = ppp_pkg::OP_POS_RA;
                n_state  = ppp_pkg::S_POS_R0;
            end
            ppp_pkg::S_POS_R0: begin
                o_cmd.op = ppp_pkg::OP_POS_R0;
                n_state  = ppp_pkg::S_POS_R1;
            end
            ppp_pkg::S_POS_R1: begin
                o_cmd.op = ppp_pkg::OP_POS_R1;
                n_state  = ppp_pkg::S_POS_W;
            end
            ppp_pkg::S_POS_W: begin
                o_cmd.op = ppp_pkg::OP_POS_W;
                n_state  = ppp_pkg::S_POS_D;
            end
            ppp_pkg::S_POS_D: begin
                o_cmd.op = ppp_pkg::OP_POS_D;
                n_state  = ppp_pkg::S_POS_MX;
            end
            ppp_pkg::S_POS_MX: begin
                o_cmd.op = ppp_pkg::OP_POS_MX;
                n_state  = ppp_pkg::S_POS_MY;
            end
            ppp_pkg::S_POS_MY: begin
                o_cmd.op = ppp_pkg::OP_POS_MY;
                n_state  = ppp_pkg::S_POS_FIN;
            end
            ppp_pkg::S_POS_FIN: begin
                o_cmd.op = ppp_pkg::OP_POS_FIN;
                n_state  = ppp_pkg::S_DONE;
            end
            ppp_pkg::S_CL_R1: begin
                o_cmd.op = ppp_pkg::OP_CL_R1;
                n_state  = ppp_pkg::S_CL_B;
            end
            ppp_pkg::S_CL_B: begin
                o_cmd.op = ppp_pkg::OP_CL_B;
                n_state  = ppp_pkg::S_CL_D;
            end
            ppp_pkg::S_CL_D: begin
                o_cmd.op = ppp_pkg::OP_CL_D;
                n_state  = ppp_pkg::S_CL_M1;
            end
            ppp_pkg::S_CL_M1: begin
                o_cmd.op = ppp_pkg::OP_CL_M1;
                n_state  = ppp_pkg::S_CL_M2;
            end
            ppp_pkg::S_CL_M2: begin
                o_cmd.op = ppp_pkg::OP_CL_M2;
                n_state  = ppp_pkg::S_CL_M3;
            end
            ppp_pkg::S_CL_M3: begin
                o_cmd.op = ppp_pkg::OP_CL_M3;
                n_state  = ppp_pkg::S_CL_M4;
            end
            ppp_pkg::S_CL_M4: begin
                o_cmd.op = ppp_pkg::OP_CL_M4;
                n_state  = ppp_pkg::S_CL_M5;
            end
            ppp_pkg::S_CL_M5: begin
                o_cmd.op = ppp_pkg::OP_CL_M5;
                n_state  = ppp_pkg::S_CL_T;
            end
            ppp_pkg::S_CL_T: begin
                o_cmd.op = ppp_pkg::OP_CL_T;
                n_state  = (i_st.tcase == ppp_pkg::TC_DIV) ? ppp_pkg::S_CL_DIV
                                                           : ppp_pkg::S_CL_CX;
            end
            ppp_pkg::S_CL_DIV: begin
                o_cmd.op = ppp_pkg::OP_CL_DIV;
                if (i_st.proj_last) begin
                    n_state = ppp_pkg::S_CL_CX;
                end
            end
            ppp_pkg::S_CL_CX: begin
                o_cmd.op = ppp_pkg::OP_CL_CX;
                n_state  = ppp_pkg::S_CL_CY;
            end
            ppp_pkg::S_CL_CY: begin
                o_cmd.op = ppp_pkg::OP_CL_CY;
                n_state  = ppp_pkg::S_CL_EX;
            end
            ppp_pkg::S_CL_EX: begin
                o_cmd.op = ppp_pkg::OP_CL_EX;
                n_state  = ppp_pkg::S_CL_EY;
            end
            ppp_pkg::S_CL_EY: begin
                o_cmd.op = ppp_pkg::OP_CL_EY;
                n_state  = ppp_pkg::S_CL_CMP;
            end
            ppp_pkg::S_CL_CMP: begin
                o_cmd.op = ppp_pkg::OP_CL_CMP;
                n_state  = i_st.seg_last ? ppp_pkg::S_FD_INIT : ppp_pkg::S_CL_NEXT;
            end
            ppp_pkg::S_CL_NEXT: begin
                o_cmd.op = ppp_pkg::OP_CL_NEXT;
                n_state  = ppp_pkg::S_CL_B;
            end
            ppp_pkg::S_FD_INIT: begin
                o_cmd.op = ppp_pkg::OP_FD_INIT;
                n_state  = ppp_pkg::S_FD;
            end
            ppp_pkg::S_FD: begin
                o_cmd.op = ppp_pkg::OP_FD;
                if (i_st.fd_last) begin
                    n_state = ppp_pkg::S_FD_END;
                end
            end
            ppp_pkg::S_FD_END: begin
                o_cmd.op = ppp_pkg::OP_FD_END;
                n_state  = ppp_pkg::S_DONE;
            end
            ppp_pkg::S_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.op = ppp_pkg::OP_EMIT;
                    n_state  = ppp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ppp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/ppp_dp.sv */
// Datapath for the polyline core: vertex RAM, shared multiplier, dividers,
// best-candidate registers and the output register. Depends on ppp_pkg, ppp_ram.
module ppp_dp #(
    parameter int MAX_POINTS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ppp_pkg::t_cmd                     i_cmd,
    output ppp_pkg::t_stat                    o_st,
    input  logic [1:0]                        i_req_type,
    input  logic signed [ppp_pkg::CRD_W-1:0]  i_point_x,
    input  logic signed [ppp_pkg::CRD_W-1:0]  i_point_y,
    input  logic [ppp_pkg::PAR_W-1:0]         i_path_param,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic signed [ppp_pkg::CRD_W-1:0]  o_out_x,
    output logic signed [ppp_pkg::CRD_W-1:0]  o_out_y,
    output logic [ppp_pkg::PAR_W-1:0]         o_out_param,
    output logic [1:0]                        o_status
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int CRD_W = ppp_pkg::CRD_W;
    localparam int PAR_W = ppp_pkg::PAR_W;
    localparam int DIF_W = ppp_pkg::DIF_W;
    localparam int MUL_W = ppp_pkg::MUL_W;
    localparam int PRD_W = ppp_pkg::PRD_W;
    localparam int DST_W = ppp_pkg::DST_W;
    localparam int FD_BITS = ppp_pkg::FD_BITS;
    localparam int CNT_W = ppp_pkg::CNT_W;

    ppp_pkg::t_req            r_req;
    logic signed [CRD_W-1:0]  r_qx, r_qy, r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic [PAR_W-1:0]         r_param, r_t;
    logic [CW-1:0]            r_count;
    logic [AW-1:0]            r_idx;
    logic signed [DIF_W-1:0]  r_dx, r_dy, r_wx, r_wy;
    logic signed [PRD_W-1:0]  r_prod, r_dot, r_len, r_rem;
    logic [DST_W-1:0]         r_dist, r_best_d;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_have;
    logic [AW-1:0]            r_best_i;
    logic [PAR_W-1:0]         r_best_t;
    logic signed [CRD_W-1:0]  r_best_x, r_best_y;
    logic [FD_BITS-1:0]       r_num;
    logic [CW-1:0]            r_frem;
    logic signed [CRD_W-1:0]  r_res_x, r_res_y;
    logic [PAR_W-1:0]         r_res_p;
    logic [1:0]               r_res_s;
    logic                     r_ovalid;
    logic signed [CRD_W-1:0]  r_ox, r_oy;
    logic [PAR_W-1:0]         r_op;
    logic [1:0]               r_os;

    logic [CW-1:0]            nseg;
    logic                     full;
    logic                     we;
    logic [AW-1:0]            addr;
    logic [2*CRD_W-1:0]       rdata;
    logic signed [MUL_W-1:0]  ma, mb;
    logic signed [PRD_W-1:0]  rnd_sum, rem2;
    logic signed [CRD_W-1:0]  rnd24;
    logic signed [DIF_W-1:0]  ex, ey;
    logic [DST_W-1:0]         sum_d;
    logic [CW-1:0]            idx_raw;
    logic [CW:0]              frem_n;
    logic                     fq;
    ppp_pkg::t_tcase          tcase;

    assign nseg = r_count - CW'(1);
    assign full = (r_count == CW'(MAX_POINTS));
    assign we   = (i_cmd.op == ppp_pkg::OP_ADD) && !full;

    always_comb begin
        unique case (i_cmd.op)
            ppp_pkg::OP_ADD:                       addr = r_count[AW-1:0];
            ppp_pkg::OP_POS_R1, ppp_pkg::OP_CL_R1,
            ppp_pkg::OP_CL_NEXT:                   addr = r_idx + AW'(1);
            default:                               addr = r_idx;
        endcase
    end

    ppp_ram #(
        .WIDTH (2 * CRD_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (addr),
        .i_wdata ({r_qx, r_qy}),
        .o_rdata (rdata)
    );

    assign ex = DIF_W'(r_qx) - DIF_W'(r_cx);
    assign ey = DIF_W'(r_qy) - DIF_W'(r_cy);

    always_comb begin
        ma = '0;
        mb = '0;
        case (i_cmd.op)
            ppp_pkg::OP_POS_T: begin
                ma = $signed(MUL_W'(nseg));
                mb = $signed(MUL_W'(r_param));
            end
            ppp_pkg::OP_POS_MX, ppp_pkg::OP_CL_CX: begin
                ma = MUL_W'(r_dx);
                mb = $signed(MUL_W'(r_t));
            end
            ppp_pkg::OP_POS_MY, ppp_pkg::OP_CL_CY: begin
                ma = MUL_W'(r_dy);
                mb = $signed(MUL_W'(r_t));
            end
            ppp_pkg::OP_CL_M1: begin
                ma = MUL_W'(r_wx);
                mb = MUL_W'(r_dx);
            end
            ppp_pkg::OP_CL_M2: begin
                ma = MUL_W'(r_wy);
                mb = MUL_W'(r_dy);
            end
            ppp_pkg::OP_CL_M3: begin
                ma = MUL_W'(r_dx);
                mb = MUL_W'(r_dx);
            end
            ppp_pkg::OP_CL_M4: begin
                ma = MUL_W'(r_dy);
                mb = MUL_W'(r_dy);
            end
            ppp_pkg::OP_CL_EX: begin
                ma = MUL_W'(ex);
                mb = MUL_W'(ex);
            end
            ppp_pkg::OP_CL_EY: begin
                ma = MUL_W'(ey);
                mb = MUL_W'(ey);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign rnd_sum = r_prod + PRD_W'(32768);
    assign rnd24   = rnd_sum[16 +: CRD_W];
    assign idx_raw = r_prod[16 +: CW];
    assign rem2    = r_rem <<< 1;
    assign sum_d   = r_dist + r_prod[DST_W-1:0];
    assign frem_n  = {r_frem, r_num[FD_BITS-1]};
    assign fq      = (frem_n >= (CW+1)'(nseg));

    always_comb begin
        if (r_len == '0 || r_dot[PRD_W-1] || r_dot == '0) begin
            tcase = ppp_pkg::TC_ZERO;
        end else if (r_dot >= r_len) begin
            tcase = ppp_pkg::TC_ONE;
        end else begin
            tcase = ppp_pkg::TC_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (we) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.op == ppp_pkg::OP_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PRD_W'(ma * mb);
        case (i_cmd.op)
            ppp_pkg::OP_LOAD: begin
                r_req   <= ppp_pkg::t_req'(i_req_type);
                r_qx    <= i_point_x;
                r_qy    <= i_point_y;
                r_param <= (i_path_param > ppp_pkg::ONE_Q16) ? ppp_pkg::ONE_Q16
                                                             : i_path_param;
                r_idx   <= '0;
                r_have  <= 1'b0;
            end
            ppp_pkg::OP_ADD: begin
                r_res_x <= '0;
                r_res_y <= '0;
                r_res_p <= '0;
                r_res_s <= full ? ppp_pkg::ST_FULL : ppp_pkg::ST_OK;
            end
            ppp_pkg::OP_SHORT: begin
                r_res_x <= '0;
                r_res_y <= '0;
                r_res_p <= '0;
                r_res_s <= ppp_pkg::ST_SHORT;
            end
            ppp_pkg::OP_ZERO: begin
                r_res_x <= '0;
                r_res_y <= '0;
                r_res_p <= '0;
                r_res_s <= ppp_pkg::ST_OK;
            end
            ppp_pkg::OP_POS_RA: begin
                if (idx_raw >= nseg) begin
                    r_idx <= nseg[AW-1:0];
                    r_t   <= '0;
                end else begin
                    r_idx <= idx_raw[AW-1:0];
                    r_t   <= {1'b0, r_prod[15:0]};
                end
            end
            ppp_pkg::OP_POS_R1, ppp_pkg::OP_CL_R1: begin
                r_ax <= rdata[2*CRD_W-1:CRD_W];
                r_ay <= rdata[CRD_W-1:0];
            end
            ppp_pkg::OP_POS_W: begin
                r_bx <= (r_t == '0) ? r_ax : rdata[2*CRD_W-1:CRD_W];
                r_by <= (r_t == '0) ? r_ay : rdata[CRD_W-1:0];
            end
            ppp_pkg::OP_CL_B: begin
                r_bx <= rdata[2*CRD_W-1:CRD_W];
                r_by <= rdata[CRD_W-1:0];
            end
            ppp_pkg::OP_POS_D, ppp_pkg::OP_CL_D: begin
                r_dx <= DIF_W'(r_bx) - DIF_W'(r_ax);
                r_dy <= DIF_W'(r_by) - DIF_W'(r_ay);
                r_wx <= DIF_W'(r_qx) - DIF_W'(r_ax);
                r_wy <= DIF_W'(r_qy) - DIF_W'(r_ay);
            end
            ppp_pkg::OP_POS_MY, ppp_pkg::OP_CL_CY: begin
                r_cx <= r_ax + rnd24;
            end
            ppp_pkg::OP_POS_FIN: begin
                r_res_x <= r_cx;
                r_res_y <= r_ay + rnd24;
                r_res_p <= '0;
                r_res_s <= ppp_pkg::ST_OK;
            end
            ppp_pkg::OP_CL_M2: r_dot <= r_prod;
            ppp_pkg::OP_CL_M3: r_dot <= r_dot + r_prod;
            ppp_pkg::OP_CL_M4: r_len <= r_prod;
            ppp_pkg::OP_CL_M5: r_len <= r_len + r_prod;
            ppp_pkg::OP_CL_T: begin
                r_t   <= (tcase == ppp_pkg::TC_ONE) ? ppp_pkg::ONE_Q16 : '0;
                r_rem <= r_dot;
                r_cnt <= '0;
            end
            ppp_pkg::OP_CL_DIV: begin
                if (rem2 >= r_len) begin
                    r_rem <= rem2 - r_len;
                    r_t   <= {r_t[PAR_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem2;
                    r_t   <= {r_t[PAR_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + CNT_W'(1);
            end
            ppp_pkg::OP_CL_EX: r_cy <= r_ay + rnd24;
            ppp_pkg::OP_CL_EY: r_dist <= r_prod[DST_W-1:0];
            ppp_pkg::OP_CL_CMP: begin
                if (!r_have || sum_d < r_best_d) begin
                    r_have   <= 1'b1;
                    r_best_d <= sum_d;
                    r_best_i <= r_idx;
                    r_best_t <= r_t;
                    r_best_x <= r_cx;
                    r_best_y <= r_cy;
                end
                r_ax  <= r_bx;
                r_ay  <= r_by;
                r_idx <= r_idx + AW'(1);
            end
            ppp_pkg::OP_FD_INIT: begin
                r_num  <= (FD_BITS'(r_best_i) << 16) + FD_BITS'(r_best_t)
                          + FD_BITS'(nseg >> 1);
                r_frem <= '0;
                r_cnt  <= '0;
            end
            ppp_pkg::OP_FD: begin
                r_frem <= fq ? CW'(frem_n - (CW+1)'(nseg)) : CW'(frem_n);
                r_num  <= {r_num[FD_BITS-2:0], fq};
                r_cnt  <= r_cnt + CNT_W'(1);
            end
            ppp_pkg::OP_FD_END: begin
                r_res_x <= r_best_x;
                r_res_y <= r_best_y;
                r_res_p <= (r_num > FD_BITS'(ppp_pkg::ONE_Q16)) ? ppp_pkg::ONE_Q16
                                                                : r_num[PAR_W-1:0];
                r_res_s <= ppp_pkg::ST_OK;
            end
            ppp_pkg::OP_EMIT: begin
                r_ox <= r_res_x;
                r_oy <= r_res_y;
                r_op <= r_res_p;
                r_os <= r_res_s;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_st.req        = r_req;
        o_st.full       = full;
        o_st.short_path = (r_count < CW'(2));
        o_st.seg_last   = ((CW'(r_idx) + CW'(1)) == nseg);
        o_st.tcase      = tcase;
        o_st.proj_last  = (r_cnt == CNT_W'(ppp_pkg::PROJ_BITS - 1));
        o_st.fd_last    = (r_cnt == CNT_W'(FD_BITS - 1));
        o_st.out_free   = !r_ovalid || !i_stall;
    end

    assign o_valid     = r_ovalid;
    assign o_out_x     = r_ox;
    assign o_out_y     = r_oy;
    assign o_out_param = r_op;
    assign o_status    = r_os;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("vertex count above capacity");

    a_add_incr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == ppp_pkg::OP_ADD && !full) |=> r_count == $past(r_count) + CW'(1))
        else $error("accepted vertex not counted");

    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == ppp_pkg::OP_CL_CX) |-> r_t <= ppp_pkg::ONE_Q16)
        else $error("projection fraction above one");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == ppp_pkg::OP_EMIT) |-> (!r_ovalid || !i_stall))
        else $error("result overwrites a pending transaction");

endmodule
